### hdl/pie_pkg.sv
// shared types and constants of the png idat payload extractor
`default_nettype none

package pie_pkg;

    localparam int SIG_BYTES_DEFAULT = 8;

    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    localparam logic [31:0] HEADER_FIELD_BYTES = 32'd4;
    localparam logic [31:0] CRC_BYTES          = 32'd4;
    localparam logic [31:0] TOTAL_MAX          = 32'hFFFF_FFFF;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef enum logic [5:0] {
        PH_SIG  = 6'b000001,
        PH_LEN  = 6'b000010,
        PH_TYPE = 6'b000100,
        PH_DATA = 6'b001000,
        PH_CRC  = 6'b010000,
        PH_HALT = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        RUN_NONE   = 2'd0,
        RUN_INSIDE = 2'd1,
        RUN_BROKEN = 2'd2
    } run_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } in_stage_t;

endpackage

`default_nettype wire

### hdl/pie_in_stage.sv
// input register stage holding one byte transaction
`default_nettype none

module pie_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_in_byte,
    output pie_pkg::in_stage_t     stage,
    input  wire logic              take
);
    import pie_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;

    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (s_ready) begin
            valid_next = s_valid;
            data_next  = s_in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

endmodule

`default_nettype wire

### hdl/pie_parser.sv
// chunk parser state and result register
`default_nettype none

module pie_parser #(
    parameter int SIGNATURE_BYTES = pie_pkg::SIG_BYTES_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire pie_pkg::in_stage_t stage,
    output logic                    take,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_result_kind,
    output logic [7:0]              m_payload_byte,
    output logic [31:0]             m_idat_total
);
    import pie_pkg::*;

    localparam logic [31:0] SIG_LEN = 32'(SIGNATURE_BYTES);
    localparam phase_t PHASE_INIT = (SIGNATURE_BYTES == 0) ? PH_LEN : PH_SIG;

    phase_t      phase_reg, phase_next;
    run_t        run_reg, run_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] type_reg, type_next;
    logic [31:0] total_reg, total_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  pbyte_reg, pbyte_next;
    logic [31:0] otot_reg, otot_next;

    logic        emit;
    logic [1:0]  emit_kind;
    logic [7:0]  emit_byte;
    logic [31:0] emit_total;
    logic [31:0] count_inc;
    logic [31:0] type_shift;
    logic [7:0]  b;

    assign take       = stage.valid && (!out_valid_reg || m_ready);
    assign b          = stage.data;
    assign count_inc  = count_reg + 32'd1;
    assign type_shift = {type_reg[23:0], b};

    always_comb begin
        phase_next = phase_reg;
        run_next   = run_reg;
        count_next = count_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        total_next = total_reg;
        emit       = 1'b0;
        emit_kind  = KIND_DATA;
        emit_byte  = 8'd0;
        emit_total = 32'd0;
        unique case (phase_reg)
            PH_SIG: begin
                count_next = count_inc;
                if (count_inc >= SIG_LEN) begin
                    count_next = 32'd0;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                len_next   = {len_reg[23:0], b};
                count_next = count_inc;
                if (count_inc >= HEADER_FIELD_BYTES) begin
                    count_next = 32'd0;
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                type_next  = type_shift;
                count_next = count_inc;
                if (count_inc >= HEADER_FIELD_BYTES) begin
                    count_next = 32'd0;
                    phase_next = (len_reg == 32'd0) ? PH_CRC : PH_DATA;
                    if (type_shift == TYPE_IEND) begin
                        count_next = count_inc;
                        phase_next = PH_HALT;
                        emit       = 1'b1;
                        emit_kind  = KIND_DONE;
                        emit_total = total_reg;
                    end else if (type_shift == TYPE_IDAT) begin
                        if (run_reg == RUN_BROKEN) begin
                            count_next = count_inc;
                            phase_next = PH_HALT;
                            emit       = 1'b1;
                            emit_kind  = KIND_ERROR;
                        end else begin
                            run_next = RUN_INSIDE;
                        end
                    end else if (run_reg == RUN_INSIDE) begin
                        run_next = RUN_BROKEN;
                    end
                end
            end
            PH_DATA: begin
                count_next = count_inc;
                if (count_inc >= len_reg) begin
                    count_next = 32'd0;
                    phase_next = PH_CRC;
                end
                if (type_reg == TYPE_IDAT) begin
                    if (total_reg != TOTAL_MAX) begin
                        total_next = total_reg + 32'd1;
                    end
                    emit      = 1'b1;
                    emit_kind = KIND_DATA;
                    emit_byte = b;
                end
            end
            PH_CRC: begin
                count_next = count_inc;
                if (count_inc >= CRC_BYTES) begin
                    count_next = 32'd0;
                    len_next   = 32'd0;
                    type_next  = 32'd0;
                    phase_next = PH_LEN;
                end
            end
            PH_HALT: begin
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        pbyte_next     = pbyte_reg;
        otot_next      = otot_reg;
        if (take) begin
            out_valid_next = emit;
            kind_next      = emit_kind;
            pbyte_next     = emit_byte;
            otot_next      = emit_total;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PHASE_INIT;
            run_reg       <= RUN_NONE;
            count_reg     <= 32'd0;
            len_reg       <= 32'd0;
            type_reg      <= 32'd0;
            total_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg <= phase_next;
                run_reg   <= run_next;
                count_reg <= count_next;
                len_reg   <= len_next;
                type_reg  <= type_next;
                total_reg <= total_next;
            end
            out_valid_reg <= out_valid_next;
        end
        kind_reg  <= kind_next;
        pbyte_reg <= pbyte_next;
        otot_reg  <= otot_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_result_kind  = kind_reg;
    assign m_payload_byte = pbyte_reg;
    assign m_idat_total   = otot_reg;

endmodule

`default_nettype wire

### hdl/png_idat_payload_extractor_top.sv
// png idat payload extractor: byte stream in, idat payload and status out
//
// input channel (s_valid, s_ready, s_in_byte) takes the png file one byte per
// transaction, from offset zero. the signature bytes are skipped, then each
// chunk header is parsed; idat payload bytes leave on the result channel
// (m_valid, m_ready, m_result_kind, m_payload_byte, m_idat_total) as kind 0.
// iend gives kind 1 with the saturating idat byte total; an idat after an
// interrupted idat run gives kind 2. after either the block drops all input.
// a byte accepted goes into the input register, then through parser logic into
// the result register.
// throughput: one byte per cycle while results are taken, set by the single
// parser stage. when the receiver stalls with a result pending, one more byte
// is held in the input register and s_ready falls until the result is taken.
// reset (aresetn low, synchronous) clears both valid flags; the parser returns
// to the signature skip phase, or to the length phase if SIGNATURE_BYTES is 0.
`default_nettype none

module png_idat_payload_extractor_top #(
    parameter int SIGNATURE_BYTES = pie_pkg::SIG_BYTES_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_kind,
    output logic [7:0]       m_payload_byte,
    output logic [31:0]      m_idat_total
);
    import pie_pkg::*;

    in_stage_t stage;
    logic      take;

    pie_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .stage     (stage),
        .take      (take)
    );

    pie_parser #(
        .SIGNATURE_BYTES (SIGNATURE_BYTES)
    ) u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .stage          (stage),
        .take           (take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_payload_byte (m_payload_byte),
        .m_idat_total   (m_idat_total)
    );

endmodule

`default_nettype wire

### test/pie_result_checker.sv
`timescale 1ns / 1ps
// checker for the png idat payload extractor: predicts results from the byte stream and compares
module pie_result_checker #(
    parameter int SIGNATURE_BYTES = pie_pkg::SIG_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_result_kind,
    input  logic [7:0]  m_payload_byte,
    input  logic [31:0] m_idat_total,
    output int          mismatch_count,
    output int          results_pending,
    output int          payload_results,
    output int          done_results,
    output int          error_results
);
    import pie_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  payload;
        logic [31:0] total;
    } extract_result_t;

    extract_result_t predicted_results[$];
    extract_result_t oldest;

    phase_t      parse_phase;
    run_t        run_state;
    logic [31:0] phase_bytes;
    logic [31:0] chunk_len;
    logic [31:0] chunk_tag;
    logic [31:0] idat_bytes;
    int          errors;
    int          n_payload;
    int          n_done;
    int          n_error;

    task automatic parse_byte(input logic [7:0] b);
        extract_result_t r;
        case (parse_phase)
            PH_SIG: begin
                phase_bytes++;
                if (phase_bytes >= SIGNATURE_BYTES) begin
                    phase_bytes = '0;
                    parse_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                chunk_len = {chunk_len[23:0], b};
                phase_bytes++;
                if (phase_bytes >= HEADER_FIELD_BYTES) begin
                    phase_bytes = '0;
                    parse_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                chunk_tag = {chunk_tag[23:0], b};
                phase_bytes++;
                if (phase_bytes >= HEADER_FIELD_BYTES) begin
                    if (chunk_tag == TYPE_IEND) begin
                        parse_phase = PH_HALT;
                        r = '{KIND_DONE, 8'h00, idat_bytes};
                        predicted_results.push_back(r);
                    end else if (chunk_tag == TYPE_IDAT && run_state == RUN_BROKEN) begin
                        parse_phase = PH_HALT;
                        r = '{KIND_ERROR, 8'h00, 32'h0};
                        predicted_results.push_back(r);
                    end else begin
                        if (chunk_tag == TYPE_IDAT) begin
                            run_state = RUN_INSIDE;
                        end else if (run_state == RUN_INSIDE) begin
                            run_state = RUN_BROKEN;
                        end
                        phase_bytes = '0;
                        if (chunk_len == 0) begin
                            parse_phase = PH_CRC;
                        end else begin
                            parse_phase = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA: begin
                phase_bytes++;
                if (phase_bytes >= chunk_len) begin
                    phase_bytes = '0;
                    parse_phase = PH_CRC;
                end
                if (chunk_tag == TYPE_IDAT) begin
                    if (idat_bytes != TOTAL_MAX) begin
                        idat_bytes++;
                    end
                    r = '{KIND_DATA, b, 32'h0};
                    predicted_results.push_back(r);
                end
            end
            PH_CRC: begin
                phase_bytes++;
                if (phase_bytes >= CRC_BYTES) begin
                    phase_bytes = '0;
                    chunk_len   = '0;
                    chunk_tag   = '0;
                    parse_phase = PH_LEN;
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            if (SIGNATURE_BYTES == 0) begin
                parse_phase = PH_LEN;
            end else begin
                parse_phase = PH_SIG;
            end
            run_state   = RUN_NONE;
            phase_bytes = '0;
            chunk_len   = '0;
            chunk_tag   = '0;
            idat_bytes  = '0;
            predicted_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_in_byte);
            end
            if (m_valid && m_ready) begin
                case (m_result_kind)
                    KIND_DATA: n_payload++;
                    KIND_DONE: n_done++;
                    default:   n_error++;
                endcase
                if (predicted_results.size() == 0) begin
                    $error("result_kind: no result expected, got %0d", m_result_kind);
                    errors++;
                end else begin
                    oldest = predicted_results.pop_front();
                    if (m_result_kind !== oldest.kind) begin
                        $error("result_kind: expected %0d, got %0d", oldest.kind, m_result_kind);
                        errors++;
                    end
                    if (m_payload_byte !== oldest.payload) begin
                        $error("payload_byte: expected 0x%02h, got 0x%02h",
                               oldest.payload, m_payload_byte);
                        errors++;
                    end
                    if (m_idat_total !== oldest.total) begin
                        $error("idat_total: expected %0d, got %0d", oldest.total, m_idat_total);
                        errors++;
                    end
                end
            end
        end
        mismatch_count  <= errors;
        results_pending <= predicted_results.size();
        payload_results <= n_payload;
        done_results    <= n_done;
        error_results   <= n_error;
    end

endmodule

### test/png_idat_payload_extractor_top_tb.sv
`timescale 1ns / 1ps
// testbench top for the png idat payload extractor: builds a png byte stream, drives it, gives the verdict
module png_idat_payload_extractor_top_tb;
    import pie_pkg::*;

    localparam int BODY_BYTES  = 1300;
    localparam int LONG_HOLD   = 150;
    localparam int TAIL_CYCLES = 16;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum int {END_IEND, END_BROKEN_RUN, END_ENDLESS_IDAT, END_ENDLESS_SKIP} stream_end_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [1:0]  m_result_kind;
    logic [7:0]  m_payload_byte;
    logic [31:0] m_idat_total;

    int mismatch_count;
    int results_pending;
    int payload_results;
    int done_results;
    int error_results;

    logic [7:0]  file_bytes[$];
    idle_mode_t  idle_mode    = IDLE_NONE;
    stream_end_t stream_end   = END_IEND;
    int          hold_at      = -1;
    bit          hold_request = 1'b0;
    bit          hold_served  = 1'b0;

    png_idat_payload_extractor_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_payload_byte (m_payload_byte),
        .m_idat_total   (m_idat_total)
    );

    pie_result_checker result_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_payload_byte  (m_payload_byte),
        .m_idat_total    (m_idat_total),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending),
        .payload_results (payload_results),
        .done_results    (done_results),
        .error_results   (error_results)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int idle_pct(input bit receiver_side);
        case (idle_mode)
            IDLE_SENDER:   return receiver_side ? 0 : 87;
            IDLE_RECEIVER: return receiver_side ? 87 : 0;
            IDLE_BOTH:     return 38;
            default:       return 0;
        endcase
    endfunction

    task automatic append_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--) begin
            file_bytes.push_back(w[8*k +: 8]);
        end
    endtask

    function automatic logic [31:0] other_tag();
        logic [31:0] t;
        case ($urandom_range(0, 3))
            0:       t = TYPE_IDAT ^ (32'h1 << $urandom_range(0, 31));
            1:       t = TYPE_IEND ^ (32'h1 << $urandom_range(0, 31));
            2:       t = 32'h4948_4452;
            default: t = $urandom();
        endcase
        if (t == TYPE_IDAT || t == TYPE_IEND) begin
            t = 32'h504C_5445;
        end
        return t;
    endfunction

    task automatic append_chunk(input logic [31:0] len, input logic [31:0] tag);
        append_word(len);
        append_word(tag);
        for (int k = 0; k < len; k++) begin
            file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        append_word($urandom());
    endtask

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result side: random stalls, plus one long hold-off so the block backs up
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request && !hold_served) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_served = 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
                @(posedge aclk);
            end
        end
    end

    initial begin
        int run_start;
        int n_post;
        int pick;
        logic [31:0] len;

        // signature, then a zero length chunk whose tag is one bit off iend
        file_bytes = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
        append_word(32'h0);
        append_word(TYPE_IEND ^ 32'h1);
        append_word(32'hFFFF_0000);

        repeat ($urandom_range(1, 4)) append_chunk($urandom_range(0, 6), other_tag());

        run_start = file_bytes.size();
        while (file_bytes.size() < BODY_BYTES) begin
            pick = $urandom_range(0, 15);
            if (pick < 2) begin
                len = 32'h0;
            end else if (pick == 2) begin
                len = $urandom_range(100, 200);
            end else begin
                len = $urandom_range(1, 24);
            end
            append_chunk(len, TYPE_IDAT);
        end
        hold_at = (run_start + file_bytes.size()) / 2;

        stream_end = stream_end_t'($urandom_range(0, 3));
        n_post = $urandom_range(0, 3);
        if (stream_end == END_BROKEN_RUN && n_post == 0) begin
            n_post = 1;
        end
        if (stream_end == END_ENDLESS_IDAT) begin
            n_post = 0;
        end
        repeat (n_post) append_chunk($urandom_range(0, 6), other_tag());

        case (stream_end)
            END_IEND: begin
                append_word($urandom());
                append_word(TYPE_IEND);
            end
            END_BROKEN_RUN: begin
                append_word($urandom_range(0, 8));
                append_word(TYPE_IDAT);
            end
            END_ENDLESS_IDAT: begin
                append_word({1'b1, 31'($urandom())});
                append_word(TYPE_IDAT);
            end
            default: begin
                append_word({1'b1, 31'($urandom())});
                append_word(other_tag());
            end
        endcase
        repeat (stream_end == END_ENDLESS_IDAT ? 200 : 24) begin
            file_bytes.push_back(8'($urandom_range(0, 255)));
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < file_bytes.size(); i++) begin
            idle_mode = idle_mode_t'((i * 5 / file_bytes.size()) % 4);
            if (i == hold_at) begin
                hold_request = 1'b1;
            end
            while ($urandom_range(0, 99) < idle_pct(1'b0)) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid   <= 1'b1;
            s_in_byte <= file_bytes[i];
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
        end
        s_valid <= 1'b0;
        @(posedge aclk);

        while (results_pending != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent a %0d byte png stream, ending %s, with and without idle cycles",
                 file_bytes.size(), stream_end.name());
        $display("took %0d payload bytes, %0d done and %0d error transactions",
                 payload_results, done_results, error_results);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
